/* design/crse_pkg.sv */
package crse_pkg;

    // Table and field sizes
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int COORD_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 21;
    localparam int PROD_W     = COORD_W + WGT_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int OUT_W      = 32;
    localparam int RAM_W      = 2 * COORD_W;
    localparam int LANES      = 4;

    // Stream packing
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 2 * OUT_W;
    localparam int M_TUSER_W = 3;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_POS   = 2'd1;
    localparam logic [1:0] OP_GRAD  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_WRITE = 2'd1;
    localparam logic [1:0] STATUS_OOR   = 2'd2;

    // Classified request kinds passed from front to back
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_POS   = 3'd1;
    localparam logic [2:0] KIND_GRAD  = 3'd2;
    localparam logic [2:0] KIND_NOP   = 3'd3;
    localparam logic [2:0] KIND_OOR   = 3'd4;

    // Point count limits
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    // Arithmetic constants
    localparam logic signed [WGT_W-1:0] WGT_ONE    = WGT_W'(1) << FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << FRAC_W;
    localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN    = SUM_W'(-64'sd2147483648);

    typedef struct packed {
        logic [2:0]         kind;
        logic [IDX_W-1:0]   idx0;
        logic [IDX_W-1:0]   idx1;
        logic [IDX_W-1:0]   idx2;
        logic [IDX_W-1:0]   idx3;
        logic [IDX_W-1:0]   widx;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [FRAC_W-1:0]  frac;
    } crse_item_t;

    // Saturate a rounded sum to the output width; top bit flags clipping.
    function automatic logic [OUT_W:0] clip_out(input logic signed [SUM_W-1:0] v);
        if (v > SAT_MAX) begin
            return {1'b1, OUT_W'(SAT_MAX)};
        end else if (v < SAT_MIN) begin
            return {1'b1, OUT_W'(SAT_MIN)};
        end
        return {1'b0, v[OUT_W-1:0]};
    endfunction

endpackage

/* design/catmull_rom_spline_eval_top.sv */
// Channel   Dir  Fields (low bit first)
// s_        in   tdata: point_index, point_x, point_y, seg_index, seg_frac, wrap_mode
//                tuser: opcode
// m_        out  tdata: out_x, out_y;  tuser: status, saturated
// apb       in   point_count at byte address 0
//
// One request per cycle is accepted and one result per cycle is produced
// while the output is not stalled. A request is written into the two-entry
// queue at acceptance, popped when the pipe advances, and then passes the six
// pipe registers (point read, t cubed, weights, products, sums, round and
// saturate). The four point reads per evaluation come from four copies of the
// point table, one read port each.
// Reset is synchronous and active low; the point table is not cleared.
// A stalled result holds the whole evaluation pipe; the queue keeps taking
// requests until it fills.
module catmull_rom_spline_eval_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_index[3:0], point_x[27:4], point_y[51:28], seg_index[55:52],
    // seg_frac[71:56], wrap_mode[72], zero fill above
    input  logic [crse_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [crse_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x[31:0], out_y[63:32]
    output logic [crse_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0], saturated[2]
    output logic [crse_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [crse_pkg::CNT_W-1:0] point_count_reg;
    logic                       q_full, q_empty, q_push, q_pop;
    crse_pkg::crse_item_t       push_item, pop_item;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-crse_pkg::CNT_W){1'b0}}, point_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= crse_pkg::CNT_MIN;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            point_count_reg <= pwdata[crse_pkg::CNT_W-1:0];
        end
    end

    crse_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .opcode      (s_tuser[1:0]),
        .point_index (s_tdata[3:0]),
        .point_x     (s_tdata[27:4]),
        .point_y     (s_tdata[51:28]),
        .seg_index   (s_tdata[55:52]),
        .seg_frac    (s_tdata[71:56]),
        .wrap_mode   (s_tdata[72]),
        .point_count (point_count_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    crse_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_item),
        .pop     (q_pop),
        .dout    (pop_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    crse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* design/crse_ram.sv */
module crse_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/crse_front.sv */
module crse_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    opcode,
    input  logic [crse_pkg::IDX_W-1:0]    point_index,
    input  logic [crse_pkg::COORD_W-1:0]  point_x,
    input  logic [crse_pkg::COORD_W-1:0]  point_y,
    input  logic [crse_pkg::IDX_W-1:0]    seg_index,
    input  logic [crse_pkg::FRAC_W-1:0]   seg_frac,
    input  logic                          wrap_mode,
    input  logic [crse_pkg::CNT_W-1:0]    point_count,
    input  logic                          q_full,
    output logic                          q_push,
    output crse_pkg::crse_item_t          q_item
);

    logic [crse_pkg::CNT_W-1:0] cnt;
    logic [crse_pkg::CNT_W-1:0] seg_mod;
    logic [crse_pkg::CNT_W-1:0] nxt1;
    logic [crse_pkg::CNT_W-1:0] nxt2;
    logic [crse_pkg::CNT_W-1:0] prv;
    logic [crse_pkg::CNT_W-1:0] seg_ext;
    logic                       past_end;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign seg_ext  = {1'b0, seg_index};

    // Clamp the point count to the supported range.
    always_comb begin
        if (point_count < crse_pkg::CNT_MIN) begin
            cnt = crse_pkg::CNT_MIN;
        end else if (point_count > crse_pkg::CNT_MAX) begin
            cnt = crse_pkg::CNT_MAX;
        end else begin
            cnt = point_count;
        end
    end

    // Segment start modulo the count; three subtractions cover the smallest count.
    always_comb begin
        seg_mod = seg_ext;
        for (int k = 0; k < 3; k++) begin
            if (seg_mod >= cnt) begin
                seg_mod = seg_mod - cnt;
            end
        end
        nxt1 = seg_mod + 5'd1;
        if (nxt1 == cnt) begin
            nxt1 = '0;
        end
        nxt2 = nxt1 + 5'd1;
        if (nxt2 == cnt) begin
            nxt2 = '0;
        end
        prv = (seg_mod == '0) ? cnt - 5'd1 : seg_mod - 5'd1;
    end

    assign past_end = (seg_ext + 5'd3) >= cnt;

    // Classify the request and pick the four point slots.
    always_comb begin
        q_item      = '0;
        q_item.widx = point_index;
        q_item.px   = point_x;
        q_item.py   = point_y;
        q_item.frac = seg_frac;
        if (wrap_mode) begin
            q_item.idx0 = prv[crse_pkg::IDX_W-1:0];
            q_item.idx1 = seg_mod[crse_pkg::IDX_W-1:0];
            q_item.idx2 = nxt1[crse_pkg::IDX_W-1:0];
            q_item.idx3 = nxt2[crse_pkg::IDX_W-1:0];
        end else begin
            q_item.idx0 = seg_index;
            q_item.idx1 = seg_index + 4'd1;
            q_item.idx2 = seg_index + 4'd2;
            q_item.idx3 = seg_index + 4'd3;
        end
        case (opcode)
            crse_pkg::OP_WRITE: q_item.kind = crse_pkg::KIND_WRITE;
            crse_pkg::OP_POS: begin
                q_item.kind = (!wrap_mode && past_end) ? crse_pkg::KIND_OOR
                                                       : crse_pkg::KIND_POS;
            end
            crse_pkg::OP_GRAD: begin
                q_item.kind = (!wrap_mode && past_end) ? crse_pkg::KIND_OOR
                                                       : crse_pkg::KIND_GRAD;
            end
            default: q_item.kind = crse_pkg::KIND_NOP;
        endcase
    end

endmodule

/* design/crse_queue.sv */
module crse_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  crse_pkg::crse_item_t din,
    input  logic                 pop,
    output crse_pkg::crse_item_t dout,
    output logic                 full,
    output logic                 empty
);

    crse_pkg::crse_item_t slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = slot_reg[rp_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wp_next    = push ? ~wp_reg : wp_reg;
        rp_next    = pop ? ~rp_reg : rp_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !full)
        else $error("request queue written while full");
`endif

endmodule

/* design/crse_back.sv */
module crse_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  crse_pkg::crse_item_t            q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [crse_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [crse_pkg::M_TUSER_W-1:0]  m_tuser
);

    logic en;
    logic [crse_pkg::RAM_W-1:0] rdata [crse_pkg::LANES];
    logic [crse_pkg::IDX_W-1:0] raddr [crse_pkg::LANES];
    logic                       we;

    // Stage A: point read issued, t squared
    logic                        va_reg;
    logic [2:0]                  kind_a_reg;
    logic [crse_pkg::FRAC_W-1:0] t_a_reg, t2_a_reg;
    logic [2*crse_pkg::FRAC_W-1:0] sq_a;

    // Stage B: points arrive, t cubed
    logic                        vb_reg;
    logic [2:0]                  kind_b_reg;
    logic [crse_pkg::FRAC_W-1:0] t_b_reg, t2_b_reg, t3_b_reg;
    logic [2*crse_pkg::FRAC_W-1:0] cu_b;
    logic [crse_pkg::COORD_W-1:0] px_b_reg [crse_pkg::LANES];
    logic [crse_pkg::COORD_W-1:0] py_b_reg [crse_pkg::LANES];

    // Stage C: basis weights
    logic                        vc_reg;
    logic [2:0]                  kind_c_reg;
    logic signed [crse_pkg::WGT_W-1:0]   w_c_reg [crse_pkg::LANES];
    logic signed [crse_pkg::WGT_W-1:0]   w_next [crse_pkg::LANES];
    logic signed [crse_pkg::COORD_W-1:0] px_c_reg [crse_pkg::LANES];
    logic signed [crse_pkg::COORD_W-1:0] py_c_reg [crse_pkg::LANES];
    logic signed [crse_pkg::WGT_W-1:0]   tw, t2w, t3w;

    // Stage D: products
    logic                        vd_reg;
    logic [2:0]                  kind_d_reg;
    logic signed [crse_pkg::PROD_W-1:0] prx_d_reg [crse_pkg::LANES];
    logic signed [crse_pkg::PROD_W-1:0] pry_d_reg [crse_pkg::LANES];

    // Stage E: sums
    logic                        ve_reg;
    logic [2:0]                  kind_e_reg;
    logic signed [crse_pkg::SUM_W-1:0] sx_e_reg, sy_e_reg, sx_next, sy_next;

    // Stage F: output register
    logic                               vf_reg;
    logic [crse_pkg::M_TDATA_W-1:0]     tdata_reg, tdata_next;
    logic [crse_pkg::M_TUSER_W-1:0]     tuser_reg, tuser_next;
    logic signed [crse_pkg::SUM_W-1:0]  rx, ry;
    logic [crse_pkg::OUT_W:0]           cx, cy;

    // The whole pipe advances together whenever the output slot frees up.
    assign en    = !vf_reg || m_tready;
    assign q_pop = en && !q_empty;
    assign we    = q_pop && (q_item.kind == crse_pkg::KIND_WRITE);

    assign raddr[0] = q_item.idx0;
    assign raddr[1] = q_item.idx1;
    assign raddr[2] = q_item.idx2;
    assign raddr[3] = q_item.idx3;

    // One copy of the point table per lane, all written together.
    for (genvar k = 0; k < crse_pkg::LANES; k++) begin : g_lane_ram
        crse_ram #(
            .WIDTH (crse_pkg::RAM_W),
            .DEPTH (crse_pkg::MAX_POINTS)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (q_item.widx),
            .wdata ({q_item.py, q_item.px}),
            .re    (en),
            .raddr (raddr[k]),
            .rdata (rdata[k])
        );
    end

    assign sq_a = q_item.frac * q_item.frac;
    assign cu_b = t2_a_reg * t_a_reg;

    // Basis weights at scale 2^(FRAC_W+1).
    always_comb begin
        tw  = $signed({{(crse_pkg::WGT_W-crse_pkg::FRAC_W){1'b0}}, t_b_reg});
        t2w = $signed({{(crse_pkg::WGT_W-crse_pkg::FRAC_W){1'b0}}, t2_b_reg});
        t3w = $signed({{(crse_pkg::WGT_W-crse_pkg::FRAC_W){1'b0}}, t3_b_reg});
        if (kind_b_reg == crse_pkg::KIND_GRAD) begin
            w_next[0] = crse_pkg::WGT_W'(-3 * t2w + 4 * tw - crse_pkg::WGT_ONE);
            w_next[1] = crse_pkg::WGT_W'(9 * t2w - 10 * tw);
            w_next[2] = crse_pkg::WGT_W'(-9 * t2w + 8 * tw + crse_pkg::WGT_ONE);
            w_next[3] = crse_pkg::WGT_W'(3 * t2w - 2 * tw);
        end else begin
            w_next[0] = crse_pkg::WGT_W'(-t3w + 2 * t2w - tw);
            w_next[1] = crse_pkg::WGT_W'(3 * t3w - 5 * t2w + 2 * crse_pkg::WGT_ONE);
            w_next[2] = crse_pkg::WGT_W'(-3 * t3w + 4 * t2w + tw);
            w_next[3] = crse_pkg::WGT_W'(t3w - t2w);
        end
    end

    assign sx_next = prx_d_reg[0] + prx_d_reg[1] + prx_d_reg[2] + prx_d_reg[3];
    assign sy_next = pry_d_reg[0] + pry_d_reg[1] + pry_d_reg[2] + pry_d_reg[3];

    // Round half up, saturate, and build the result.
    always_comb begin
        rx = (sx_e_reg + crse_pkg::ROUND_BIAS) >>> (crse_pkg::FRAC_W + 1);
        ry = (sy_e_reg + crse_pkg::ROUND_BIAS) >>> (crse_pkg::FRAC_W + 1);
        cx = crse_pkg::clip_out(rx);
        cy = crse_pkg::clip_out(ry);
        tdata_next = '0;
        tuser_next = '0;
        case (kind_e_reg)
            crse_pkg::KIND_POS, crse_pkg::KIND_GRAD: begin
                tdata_next = {cy[crse_pkg::OUT_W-1:0], cx[crse_pkg::OUT_W-1:0]};
                tuser_next = {cx[crse_pkg::OUT_W] | cy[crse_pkg::OUT_W],
                              crse_pkg::STATUS_DONE};
            end
            crse_pkg::KIND_WRITE: tuser_next = {1'b0, crse_pkg::STATUS_WRITE};
            crse_pkg::KIND_OOR:   tuser_next = {1'b0, crse_pkg::STATUS_OOR};
            default:              tuser_next = {1'b0, crse_pkg::STATUS_DONE};
        endcase
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else if (en) begin
            va_reg <= q_pop;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    // Payload of the stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            kind_a_reg <= q_item.kind;
            t_a_reg    <= q_item.frac;
            t2_a_reg   <= sq_a[2*crse_pkg::FRAC_W-1:crse_pkg::FRAC_W];

            kind_b_reg <= kind_a_reg;
            t_b_reg    <= t_a_reg;
            t2_b_reg   <= t2_a_reg;
            t3_b_reg   <= cu_b[2*crse_pkg::FRAC_W-1:crse_pkg::FRAC_W];

            kind_c_reg <= kind_b_reg;
            kind_d_reg <= kind_c_reg;
            kind_e_reg <= kind_d_reg;
            sx_e_reg   <= sx_next;
            sy_e_reg   <= sy_next;
            tdata_reg  <= tdata_next;
            tuser_reg  <= tuser_next;

            for (int k = 0; k < crse_pkg::LANES; k++) begin
                px_b_reg[k]  <= rdata[k][crse_pkg::COORD_W-1:0];
                py_b_reg[k]  <= rdata[k][crse_pkg::RAM_W-1:crse_pkg::COORD_W];
                w_c_reg[k]   <= w_next[k];
                px_c_reg[k]  <= $signed(px_b_reg[k]);
                py_c_reg[k]  <= $signed(py_b_reg[k]);
                prx_d_reg[k] <= px_c_reg[k] * w_c_reg[k];
                pry_d_reg[k] <= py_c_reg[k] * w_c_reg[k];
            end
        end
    end

    assign m_tvalid = vf_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

`ifndef SYNTHESIS
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == crse_pkg::STATUS_WRITE)
            |-> (m_tdata == '0 && !m_tuser[2]))
        else $error("write acknowledge carries nonzero data");
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == crse_pkg::STATUS_OOR)
            |-> (m_tdata == '0 && !m_tuser[2]))
        else $error("out-of-range result carries nonzero data");
    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(ve_reg) && $stable(va_reg)))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule
